[rtl/core/hbpd_pkg.sv]
package hbpd_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int COUNT_BITS     = 16;
  localparam int OUT_CNT_BITS   = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 + 2 * OUT_CNT_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [OUT_CNT_BITS-1:0]   out_cnt_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  // register indexes
  localparam cfg_index_t CFG_LOW  = CFG_INDEX_BITS'(0);
  localparam cfg_index_t CFG_MID  = CFG_INDEX_BITS'(1);
  localparam cfg_index_t CFG_HIGH = CFG_INDEX_BITS'(2);

  localparam sample_t LOW_RST  = SAMPLE_BITS'(29);
  localparam sample_t MID_RST  = SAMPLE_BITS'(46);
  localparam sample_t HIGH_RST = SAMPLE_BITS'(53);

  typedef struct packed {
    logic    sample_valid;
    sample_t sample;
  } in_item_t;

  // stage register contents handed to the core
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } stage_t;

  // packed with the first field in the highest bits
  typedef struct packed {
    logic     level_is_high;
    out_cnt_t beat_period;
    out_cnt_t beats_seen;
    logic     beat;
  } result_t;

endpackage

[rtl/core/hbpd_in_stage.sv]
module hbpd_in_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [hbpd_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  input  logic                                 in_tuser,
  input  logic                                 advance,
  output hbpd_pkg::stage_t                     stage
);

  logic               vld_r;
  logic               vld_nxt;
  hbpd_pkg::in_item_t item_r;
  logic               accept;

  assign in_tready = !vld_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.sample_valid <= in_tuser;
      item_r.sample       <= in_tdata[hbpd_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

[rtl/core/hbpd_core.sv]
module hbpd_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  hbpd_pkg::cfg_index_t                 cfg_index,
  input  hbpd_pkg::sample_t                    cfg_wdata,
  input  hbpd_pkg::stage_t                     stage,
  output logic                                 advance,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output hbpd_pkg::result_t                    result
);

  hbpd_pkg::sample_t low_thr_r, mid_thr_r, high_thr_r;

  logic             level_r, level_nxt;
  logic             low_arm_r, low_arm_nxt;
  logic             high_arm_r, high_arm_nxt;
  hbpd_pkg::count_t beat_total_r, beat_total_nxt;
  hbpd_pkg::count_t tick_r, tick_nxt;
  hbpd_pkg::count_t period_r, period_nxt;
  logic             beat_nxt;

  logic              out_vld_r, out_vld_nxt;
  hbpd_pkg::result_t result_r;

  hbpd_pkg::sample_t s;
  logic              sv;

  assign s  = stage.item.sample;
  assign sv = stage.item.sample_valid;

  assign advance = stage.vld && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= hbpd_pkg::LOW_RST;
      mid_thr_r  <= hbpd_pkg::MID_RST;
      high_thr_r <= hbpd_pkg::HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbpd_pkg::CFG_LOW:  low_thr_r  <= cfg_wdata;
        hbpd_pkg::CFG_MID:  mid_thr_r  <= cfg_wdata;
        hbpd_pkg::CFG_HIGH: high_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one tick: transition first, then the arm checks on the same sample
  always_comb begin
    level_nxt      = level_r;
    low_arm_nxt    = low_arm_r;
    high_arm_nxt   = high_arm_r;
    beat_total_nxt = beat_total_r;
    period_nxt     = period_r;
    tick_nxt       = tick_r;
    beat_nxt       = 1'b0;
    if (sv) begin
      if (!level_r) begin
        if ((s > mid_thr_r) && low_arm_r) begin
          level_nxt      = 1'b1;
          beat_nxt       = 1'b1;
          beat_total_nxt = beat_total_r + hbpd_pkg::COUNT_BITS'(1);
          period_nxt     = tick_r;
          tick_nxt       = '0;
          high_arm_nxt   = 1'b0;
        end
      end else begin
        if ((s < mid_thr_r) && high_arm_r) begin
          level_nxt   = 1'b0;
          low_arm_nxt = 1'b0;
        end
      end
      if (s <= low_thr_r) begin
        low_arm_nxt = 1'b1;
      end
      if (s >= high_thr_r) begin
        high_arm_nxt = 1'b1;
      end
    end
    tick_nxt = tick_nxt + hbpd_pkg::COUNT_BITS'(1);
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= 1'b1;
      low_arm_r    <= 1'b0;
      high_arm_r   <= 1'b0;
      beat_total_r <= '0;
      tick_r       <= '0;
      period_r     <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        level_r      <= level_nxt;
        low_arm_r    <= low_arm_nxt;
        high_arm_r   <= high_arm_nxt;
        beat_total_r <= beat_total_nxt;
        tick_r       <= tick_nxt;
        period_r     <= period_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r.beat          <= beat_nxt;
      result_r.beats_seen    <= hbpd_pkg::OUT_CNT_BITS'(beat_total_nxt);
      result_r.beat_period   <= hbpd_pkg::OUT_CNT_BITS'(period_nxt);
      result_r.level_is_high <= level_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign result     = result_r;

  a_beat_means_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && result_r.beat |-> result_r.level_is_high)
    else $error("beat reported while level is low");

  a_beat_restarts_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    advance && beat_nxt |=> tick_r == hbpd_pkg::COUNT_BITS'(1))
    else $error("tick counter not restarted on beat");

  a_no_sample_holds_level: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !sv |=> $stable(level_r) && $stable(low_arm_r) && $stable(high_arm_r)
      && !result_r.beat)
    else $error("level logic moved without a sample");

  a_result_tracks_total: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> result_r.beats_seen == hbpd_pkg::OUT_CNT_BITS'(beat_total_r))
    else $error("beats_seen out of step with beat total");

endmodule

[rtl/core/hysteresis_beat_period_detector.sv]
// An input transaction goes into the input register; the tick update then feeds
// the result register, which drives out_tvalid. Throughput: one transaction per
// cycle unless out_tready stalls, with the ready path running back from out_tready.
// Reset (rst_n low at a clock edge): thresholds to 29/46/53, level high,
// arms cleared, beat/tick/period counters zero, both pipeline stages empty.
module hysteresis_beat_period_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [hbpd_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // sample
  input  logic                                 in_tuser,   // sample_valid
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [hbpd_pkg::OUT_TDATA_BITS-1:0]  out_tdata,  // beat, beats_seen,
                                                           // beat_period, level_is_high
  input  logic                                 cfg_we,
  input  hbpd_pkg::cfg_index_t                 cfg_index,
  input  hbpd_pkg::sample_t                    cfg_wdata
);

  hbpd_pkg::stage_t  stage;
  hbpd_pkg::result_t result;
  logic              advance;

  hbpd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .stage     (stage)
  );

  hbpd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .stage      (stage),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .result     (result)
  );

  assign out_tdata = hbpd_pkg::OUT_TDATA_BITS'(result);

endmodule

[tb/hysteresis_beat_period_detector_tb.sv]
`timescale 1ns / 1ps

module hysteresis_beat_period_detector_tb;

  // unmapped index, must be a no-op
  localparam hbpd_pkg::cfg_index_t CFG_SPARE   = hbpd_pkg::CFG_INDEX_BITS'(3);
  localparam int                   STALL_LIMIT = 2000;
  localparam int                   HOLD_CYCLES = 60;
  localparam int                   PHASE_ITEMS = 175;
  localparam int                   MAX_REPORTS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [hbpd_pkg::IN_TDATA_BITS-1:0]  in_tdata = '0;   // sample
  logic                                in_tuser = 1'b0; // sample_valid
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  // beat, beats_seen, beat_period, level_is_high
  logic [hbpd_pkg::OUT_TDATA_BITS-1:0] out_tdata;
  logic                                cfg_we = 1'b0;
  hbpd_pkg::cfg_index_t                cfg_index = hbpd_pkg::CFG_LOW;
  hbpd_pkg::sample_t                   cfg_wdata = '0;

  hysteresis_beat_period_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the detector state
  hbpd_pkg::sample_t thr_low  = hbpd_pkg::LOW_RST;
  hbpd_pkg::sample_t thr_mid  = hbpd_pkg::MID_RST;
  hbpd_pkg::sample_t thr_high = hbpd_pkg::HIGH_RST;
  logic              lvl_high = 1'b1;
  logic              arm_low  = 1'b0;
  logic              arm_high = 1'b0;
  hbpd_pkg::count_t  beat_cnt = '0;
  hbpd_pkg::count_t  ticks    = '0;
  hbpd_pkg::count_t  period   = '0;

  hbpd_pkg::in_item_t tick_queue[$];
  hbpd_pkg::result_t  beat_reports_due[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  int err_cnt      = 0;
  int quiet_cycles = 0;

  function automatic hbpd_pkg::result_t tick_update(hbpd_pkg::in_item_t it);
    hbpd_pkg::result_t r;
    r.beat = 1'b0;
    if (it.sample_valid) begin
      if (!lvl_high) begin
        if (it.sample > thr_mid && arm_low) begin
          lvl_high = 1'b1;
          r.beat   = 1'b1;
          beat_cnt = beat_cnt + 1'b1;
          period   = ticks;
          ticks    = '0;
          arm_high = 1'b0;
        end
      end else if (it.sample < thr_mid && arm_high) begin
        lvl_high = 1'b0;
        arm_low  = 1'b0;
      end
      // arm checks run after the transition, so the same sample can re-arm
      if (it.sample <= thr_low) arm_low = 1'b1;
      if (it.sample >= thr_high) arm_high = 1'b1;
    end
    ticks = ticks + 1'b1;
    r.beats_seen    = hbpd_pkg::out_cnt_t'(beat_cnt);
    r.beat_period   = hbpd_pkg::out_cnt_t'(period);
    r.level_is_high = lvl_high;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      if (err_cnt < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        hbpd_pkg::in_item_t it;
        it = tick_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= hbpd_pkg::IN_TDATA_BITS'(it.sample);
        in_tuser  <= it.sample_valid;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off to back the pipeline up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // monitor: check the oldest expectation first, then predict for a new transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        hbpd_pkg::result_t got, want;
        got = hbpd_pkg::result_t'(out_tdata[$bits(hbpd_pkg::result_t)-1:0]);
        if (beat_reports_due.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = beat_reports_due.pop_front();
          check_field("beat", want.beat, got.beat);
          check_field("beats_seen", want.beats_seen, got.beats_seen);
          check_field("beat_period", want.beat_period, got.beat_period);
          check_field("level_is_high", want.level_is_high, got.level_is_high);
        end
      end
      if (in_tvalid && in_tready) begin
        hbpd_pkg::in_item_t it;
        it.sample_valid = in_tuser;
        it.sample       = in_tdata[hbpd_pkg::SAMPLE_BITS-1:0];
        beat_reports_due.push_back(tick_update(it));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("hysteresis_beat_period_detector verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_tick(logic valid, int unsigned smp);
    hbpd_pkg::in_item_t it;
    it.sample_valid = valid;
    it.sample       = hbpd_pkg::sample_t'(smp);
    tick_queue.push_back(it);
  endtask

  // sampled away from the rising edge so queue, valid and expectations agree
  task automatic wait_drain();
    while (tick_queue.size() != 0 || in_tvalid || beat_reports_due.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(hbpd_pkg::cfg_index_t idx, hbpd_pkg::sample_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      hbpd_pkg::CFG_LOW:  thr_low  = val;
      hbpd_pkg::CFG_MID:  thr_mid  = val;
      hbpd_pkg::CFG_HIGH: thr_high = val;
      default: ;
    endcase
  endtask

  task automatic apply_thresholds(hbpd_pkg::sample_t lo, hbpd_pkg::sample_t mid,
                                  hbpd_pkg::sample_t hi);
    write_reg(hbpd_pkg::CFG_LOW, lo);
    write_reg(CFG_SPARE, hbpd_pkg::sample_t'($urandom_range(1023)));
    write_reg(hbpd_pkg::CFG_MID, mid);
    write_reg(hbpd_pkg::CFG_HIGH, hi);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // samples cluster around the side the light is swinging to, plus noise
  function automatic hbpd_pkg::sample_t pick_sample(bit going_high);
    int r, v;
    r = $urandom_range(99);
    if (r < 20) v = $urandom_range(1023);
    else if (r < 30) v = going_high ? int'(thr_high) : int'(thr_low);
    else if (r < 40) v = int'(thr_mid) + $urandom_range(2) - 1;
    else if (going_high) v = $urandom_range(1023, thr_high);
    else v = $urandom_range(thr_low, 0);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return hbpd_pkg::sample_t'(v);
  endfunction

  initial begin
    int                ph, i, run_left;
    bit                going_high;
    hbpd_pkg::sample_t a, b, c;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct  = 16;
    rx_stall_pct = 81;

    // directed walk through the level machine at reset thresholds
    push_tick(1'b0, 1023);  // no sample: only the tick counter moves
    push_tick(1'b1, 0);     // arms low while still high
    push_tick(1'b1, 1023);  // arms high
    push_tick(1'b1, 45);    // falls to low, low disarmed
    push_tick(1'b1, 47);    // above mid but not armed: no beat
    push_tick(1'b1, 29);    // equal to low threshold arms low
    push_tick(1'b0, 0);
    push_tick(1'b0, 512);
    push_tick(1'b0, 341);
    push_tick(1'b1, 46);    // equal to mid: no beat
    push_tick(1'b1, 47);    // beat
    push_tick(1'b1, 53);    // equal to high threshold arms high
    push_tick(1'b1, 46);    // equal to mid: stays high
    push_tick(1'b1, 20);    // falls and re-arms low on the same tick
    push_tick(1'b1, 1000);  // beat, re-arms high on the same tick
    push_tick(1'b1, 0);
    push_tick(1'b1, 1023);  // beat right after
    push_tick(1'b1, 682);
    wait_drain();

    going_high = 1'b0;
    run_left   = 0;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_thresholds(hbpd_pkg::LOW_RST, hbpd_pkg::MID_RST, hbpd_pkg::HIGH_RST);
        1: apply_thresholds('0, '0, '0);
        2: apply_thresholds('1, '1, '1);
        3: apply_thresholds('0, hbpd_pkg::sample_t'(512), '1);
        4: apply_thresholds(hbpd_pkg::sample_t'($urandom_range(1023)),
                            hbpd_pkg::sample_t'($urandom_range(1023)),
                            hbpd_pkg::sample_t'($urandom_range(1023)));
        default: begin
          a = hbpd_pkg::sample_t'($urandom_range(400));
          b = hbpd_pkg::sample_t'($urandom_range(700, a));
          c = hbpd_pkg::sample_t'($urandom_range(1023, b));
          apply_thresholds(a, b, c);
        end
      endcase
      if (ph == 2) begin
        tx_idle_pct  = 81;
        rx_stall_pct = 16;
      end else if (ph == 4) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      if (ph == 1) hold_req++;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (run_left == 0) begin
          going_high = !going_high;
          run_left   = $urandom_range(6, 1);
        end
        run_left--;
        if ($urandom_range(99) < 15) push_tick(1'b0, $urandom_range(1023));
        else push_tick(1'b1, pick_sample(going_high));
      end
      wait_drain();
    end

    if (err_cnt == 0 && beat_reports_due.size() == 0) begin
      $display("hysteresis_beat_period_detector verification clean");
    end else begin
      $display("hysteresis_beat_period_detector verification failed");
    end
    $finish;
  end

endmodule
